// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the complex arithmetic unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/cplx_pkg.sv =====
// ----------------------------------------------------------------------------
// cplx_pkg
// shared types, constants and saturation helper of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cplx_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QW            = 33;
    localparam int MW            = 64;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_MUL = 2'd1,
        CMD_DIV = 2'd2,
        CMD_NOP = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [MW-1:0] den;
        logic [MW-1:0] rem_re;
        logic [MW-1:0] rem_im;
        logic [QW-1:0] low_re;
        logic [QW-1:0] low_im;
        logic [QW-1:0] q_re;
        logic [QW-1:0] q_im;
    } div_lane_t;

    // returns {overflow, value}
    function automatic logic [32:0] sat_mag(input logic neg, input logic [MW:0] m);
        logic [32:0] r;
        if (!neg)
        begin
            if (m > 65'h0_7FFF_FFFF)
                r = {1'b1, 32'h7FFF_FFFF};
            else
                r = {1'b0, m[31:0]};
        end
        else
        begin
            if (m > 65'h0_8000_0000)
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, (~m[31:0]) + 32'd1};
        end
        return r;
    endfunction

endpackage

// ===== hdl/cplx_div_cell.sv =====
// ----------------------------------------------------------------------------
// cplx_div_cell
// one restoring-division step for the real and imaginary quotient lanes
// ----------------------------------------------------------------------------
module cplx_div_cell
    import cplx_pkg::*;
(
    input  logic      clk,
    input  div_lane_t din,
    output div_lane_t dout
);

    div_lane_t     dout_reg;
    div_lane_t     dout_next;
    logic [MW:0]   r2_re;
    logic [MW:0]   r2_im;
    logic          ge_re;
    logic          ge_im;

    always_comb
    begin
        r2_re = {din.rem_re, din.low_re[QW-1]};
        r2_im = {din.rem_im, din.low_im[QW-1]};
        ge_re = r2_re >= {1'b0, din.den};
        ge_im = r2_im >= {1'b0, din.den};
        dout_next        = din;
        dout_next.rem_re = ge_re ? MW'(r2_re - {1'b0, din.den}) : r2_re[MW-1:0];
        dout_next.rem_im = ge_im ? MW'(r2_im - {1'b0, din.den}) : r2_im[MW-1:0];
        dout_next.low_re = {din.low_re[QW-2:0], 1'b0};
        dout_next.low_im = {din.low_im[QW-2:0], 1'b0};
        dout_next.q_re   = {din.q_re[QW-2:0], ge_re};
        dout_next.q_im   = {din.q_im[QW-2:0], ge_im};
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// ===== hdl/complex_add_mul_div_unit.sv =====
// ----------------------------------------------------------------------------
// complex_add_mul_div_unit
// pipelined complex add, multiply and divide on signed fixed-point operands
// ----------------------------------------------------------------------------
// A transaction is taken on every clock edge where start is high; busy is
// always low. Each result appears on res_re, res_im, overflow and div_zero
// for exactly one cycle with done high, after passing through five arithmetic
// stages, a chain of 33 division cells and one output register. The latency is
// the same for every command, so results leave in order, one per cycle at full
// rate. The sink cannot stall the pipeline.
module complex_add_mul_div_unit
    import cplx_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    output logic               done,
    output logic signed [31:0] res_re,
    output logic signed [31:0] res_im,
    output logic               overflow,
    output logic               div_zero
);

`include "assert_macros.svh"

    localparam int          CW   = MW + QW;
    localparam int          LAT  = QW + 6;
    localparam logic [MW:0] HALF = (65'd1 << FRAC_BITS) >> 1;

    typedef struct packed {
        logic        valid;
        cmd_t        op;
        logic        dz;
        logic        neg_re;
        logic        neg_im;
        logic        big_re;
        logic        big_im;
        logic [31:0] r_re;
        logic [31:0] r_im;
        logic        ovf;
    } side_t;

    // stage 0: operands
    logic               s0_valid_reg;
    cmd_t               s0_op_reg;
    logic signed [31:0] s0_a_reg, s0_b_reg, s0_c_reg, s0_d_reg;

    // stage 1: products
    side_t              s1_reg, s1_next;
    logic signed [63:0] s1_ac_reg, s1_bd_reg, s1_bc_reg, s1_ad_reg, s1_cc_reg, s1_dd_reg;

    // stage 2: sums
    side_t              s2_reg;
    logic signed [MW:0] s2_re_reg, s2_im_reg;
    logic [MW-1:0]      s2_den_reg;

    // stage 3: magnitudes
    side_t              s3_reg, s3_next;
    logic [MW-1:0]      s3_mre_reg, s3_mim_reg, s3_den_reg;

    // stage 4: rounding and divider setup
    side_t              s4_reg, s4_next;
    div_lane_t          s4_lane_reg, s4_lane_next;

    side_t              side_reg [QW];
    div_lane_t          lane [QW+1];

    logic               done_reg;
    logic [31:0]        res_re_reg, res_im_reg;
    logic               ovf_reg, dz_reg;

    logic signed [32:0] add_re, add_im;
    logic [32:0]        sat_a_re, sat_a_im;
    logic [MW:0]        m_re, m_im;
    logic [MW:0]        rnd_re, rnd_im;
    logic [32:0]        sat_m_re, sat_m_im;
    logic [CW-1:0]      dw_re, dw_im, dlim;
    div_lane_t          lo;
    side_t              so;
    logic [QW:0]        qf_re, qf_im;
    logic [32:0]        sat_d_re, sat_d_im;
    logic [31:0]        out_re_next, out_im_next;
    logic               out_ovf_next, out_dz_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_op_reg <= cmd_t'(cmd);
        s0_a_reg  <= a_re;
        s0_b_reg  <= a_im;
        s0_c_reg  <= b_re;
        s0_d_reg  <= b_im;
    end

    // stage 1
    always_comb
    begin
        add_re   = 33'(s0_a_reg) + 33'(s0_c_reg);
        add_im   = 33'(s0_b_reg) + 33'(s0_d_reg);
        sat_a_re = sat_mag(add_re[32], add_re[32] ? 65'(-add_re) : 65'(add_re));
        sat_a_im = sat_mag(add_im[32], add_im[32] ? 65'(-add_im) : 65'(add_im));
        s1_next        = '0;
        s1_next.valid  = s0_valid_reg;
        s1_next.op     = s0_op_reg;
        s1_next.dz     = (s0_c_reg == 32'sd0) && (s0_d_reg == 32'sd0);
        s1_next.r_re   = sat_a_re[31:0];
        s1_next.r_im   = sat_a_im[31:0];
        s1_next.ovf    = sat_a_re[32] | sat_a_im[32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ac_reg <= s0_a_reg * s0_c_reg;
        s1_bd_reg <= s0_b_reg * s0_d_reg;
        s1_bc_reg <= s0_b_reg * s0_c_reg;
        s1_ad_reg <= s0_a_reg * s0_d_reg;
        s1_cc_reg <= s0_c_reg * s0_c_reg;
        s1_dd_reg <= s0_d_reg * s0_d_reg;
    end

    // stage 2
    always_ff @(posedge clk)
    begin
        if (s1_reg.op == CMD_MUL)
        begin
            s2_re_reg <= $signed({s1_ac_reg[63], s1_ac_reg}) - $signed({s1_bd_reg[63], s1_bd_reg});
            s2_im_reg <= $signed({s1_bc_reg[63], s1_bc_reg}) + $signed({s1_ad_reg[63], s1_ad_reg});
        end
        else
        begin
            s2_re_reg <= $signed({s1_ac_reg[63], s1_ac_reg}) + $signed({s1_bd_reg[63], s1_bd_reg});
            s2_im_reg <= $signed({s1_bc_reg[63], s1_bc_reg}) - $signed({s1_ad_reg[63], s1_ad_reg});
        end
        s2_den_reg <= $unsigned(s1_cc_reg) + $unsigned(s1_dd_reg);
    end

    // stage 3
    always_comb
    begin
        m_re           = s2_re_reg[MW] ? 65'(-s2_re_reg) : 65'(s2_re_reg);
        m_im           = s2_im_reg[MW] ? 65'(-s2_im_reg) : 65'(s2_im_reg);
        s3_next        = s2_reg;
        s3_next.neg_re = s2_re_reg[MW];
        s3_next.neg_im = s2_im_reg[MW];
    end

    always_ff @(posedge clk)
    begin
        s3_mre_reg <= m_re[MW-1:0];
        s3_mim_reg <= m_im[MW-1:0];
        s3_den_reg <= s2_den_reg;
    end

    // stage 4
    always_comb
    begin
        rnd_re   = ({1'b0, s3_mre_reg} + HALF) >> FRAC_BITS;
        rnd_im   = ({1'b0, s3_mim_reg} + HALF) >> FRAC_BITS;
        sat_m_re = sat_mag(s3_reg.neg_re, rnd_re);
        sat_m_im = sat_mag(s3_reg.neg_im, rnd_im);
        dw_re    = {{QW{1'b0}}, s3_mre_reg} << FRAC_BITS;
        dw_im    = {{QW{1'b0}}, s3_mim_reg} << FRAC_BITS;
        dlim     = {s3_den_reg, {QW{1'b0}}};
        s4_next        = s3_reg;
        s4_next.big_re = dw_re >= dlim;
        s4_next.big_im = dw_im >= dlim;
        if (s3_reg.op == CMD_MUL)
        begin
            s4_next.r_re = sat_m_re[31:0];
            s4_next.r_im = sat_m_im[31:0];
            s4_next.ovf  = sat_m_re[32] | sat_m_im[32];
        end
        s4_lane_next.den    = s3_den_reg;
        s4_lane_next.rem_re = dw_re[CW-1:QW];
        s4_lane_next.rem_im = dw_im[CW-1:QW];
        s4_lane_next.low_re = dw_re[QW-1:0];
        s4_lane_next.low_im = dw_im[QW-1:0];
        s4_lane_next.q_re   = '0;
        s4_lane_next.q_im   = '0;
    end

    always_ff @(posedge clk)
    begin
        s4_lane_reg <= s4_lane_next;
    end

    // division cell chain
    assign lane[0] = s4_lane_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_cell
        cplx_div_cell u_cell (
            .clk  (clk),
            .din  (lane[k]),
            .dout (lane[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QW; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= s4_reg;
            for (int i = 1; i < QW; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // final rounding, saturation and selection
    always_comb
    begin
        lo       = lane[QW];
        so       = side_reg[QW-1];
        qf_re    = {1'b0, lo.q_re} + (QW+1)'(lo.rem_re >= (lo.den - lo.rem_re));
        qf_im    = {1'b0, lo.q_im} + (QW+1)'(lo.rem_im >= (lo.den - lo.rem_im));
        sat_d_re = sat_mag(so.neg_re, so.big_re ? '1 : 65'(qf_re));
        sat_d_im = sat_mag(so.neg_im, so.big_im ? '1 : 65'(qf_im));
        out_re_next  = '0;
        out_im_next  = '0;
        out_ovf_next = 1'b0;
        out_dz_next  = 1'b0;
        case (so.op)
            CMD_ADD, CMD_MUL:
            begin
                out_re_next  = so.r_re;
                out_im_next  = so.r_im;
                out_ovf_next = so.ovf;
            end
            CMD_DIV:
            begin
                if (so.dz)
                begin
                    out_dz_next = 1'b1;
                end
                else
                begin
                    out_re_next  = sat_d_re[31:0];
                    out_im_next  = sat_d_im[31:0];
                    out_ovf_next = sat_d_re[32] | sat_d_im[32];
                end
            end
            default:
            begin
                out_re_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= so.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_re_reg <= out_re_next;
        res_im_reg <= out_im_next;
        ovf_reg    <= out_ovf_next;
        dz_reg     <= out_dz_next;
    end

    assign done     = done_reg;
    assign res_re   = res_re_reg;
    assign res_im   = res_im_reg;
    assign overflow = ovf_reg;
    assign div_zero = dz_reg;

    `ASSERT_CLK(a_fixed_latency, clk, rst_n, start |-> ##LAT done, "result missing after latency")
    `ASSERT_CLK(a_dz_no_ovf, clk, rst_n, done && div_zero |-> !overflow, "div_zero with overflow")
    `ASSERT_CLK(a_dz_zero, clk, rst_n, done && div_zero |-> res_re == 0 && res_im == 0, "div_zero nonzero")
    `ASSERT_ALWAYS(a_never_busy, clk, !busy, "busy raised")

endmodule
